// File: src/dcsd_pkg.sv
// Package for the delta command stream decoder: word types, kinds, error codes,
// and the base-64 digit lookup. No dependencies.
`timescale 1ns / 1ps
package dcsd_pkg;

  typedef struct packed {
    logic [7:0] delta_byte;
    logic       start_of_delta;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal_byte;
    logic [31:0] copy_offset;
    logic [31:0] copy_count;
    logic [31:0] output_total;
    logic [31:0] trailer_value;
    logic [3:0]  error_code;
    logic        last_of_run;
  } out_word_t;

  // classified input word passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_digit;
    logic [5:0] digit;
  } cls_word_t;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [3:0] ERR_HDR_NL     = 4'd0;
  localparam logic [3:0] ERR_NO_COMMA   = 4'd1;
  localparam logic [3:0] ERR_COPY_SIZE  = 4'd2;
  localparam logic [3:0] ERR_COPY_SRC   = 4'd3;
  localparam logic [3:0] ERR_INS_SIZE   = 4'd4;
  localparam logic [3:0] ERR_INS_DELTA  = 4'd5;
  localparam logic [3:0] ERR_FINAL_SIZE = 4'd6;
  localparam logic [3:0] ERR_UNK_OP     = 4'd7;
  localparam logic [3:0] ERR_UNTERM     = 4'd8;

  localparam logic       CFG_SRC_LEN   = 1'b0;
  localparam logic       CFG_DELTA_LEN = 1'b1;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_NL    = 8'h0a;

  function automatic logic [6:0] digit_lookup(input logic [7:0] b);
    logic [6:0] c;
    c = b[6:0];
    if (c >= 7'h30 && c <= 7'h39) digit_lookup = c - 7'h30;
    else if (c >= 7'h41 && c <= 7'h5a) digit_lookup = c - 7'h41 + 7'd10;
    else if (c == 7'h5f) digit_lookup = 7'd36;
    else if (c >= 7'h61 && c <= 7'h7a) digit_lookup = c - 7'h61 + 7'd37;
    else if (c == 7'h7e) digit_lookup = 7'd63;
    else digit_lookup = 7'd64;
  endfunction

endpackage

// File: src/dcsd_front.sv
// Front end: accepts input words and classifies the digit value.
// Depends on dcsd_pkg.
`timescale 1ns / 1ps
module dcsd_front import dcsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      cls_valid,
  input  logic      cls_ready,
  output cls_word_t cls_data
);
  logic      vld_r, vld_nxt;
  cls_word_t dat_r, dat_nxt;
  logic [6:0] dv;

  assign in_ready  = !vld_r || cls_ready;
  assign cls_valid = vld_r;
  assign cls_data  = dat_r;
  assign dv = digit_lookup(in_data.delta_byte);

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (in_ready) begin
      vld_nxt = in_valid;
      dat_nxt.data = in_data.delta_byte;
      dat_nxt.start = in_data.start_of_delta;
      dat_nxt.is_digit = !dv[6];
      dat_nxt.digit = dv[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    dat_r <= dat_nxt;
  end
endmodule

// File: src/dcsd_fifo.sv
// Short queue between the front and the back.
// Depends on dcsd_pkg.
`timescale 1ns / 1ps
module dcsd_fifo import dcsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cls_word_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output cls_word_t rd_data
);
  cls_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: src/dcsd_back.sv
// Back end: parse state, command checks, result words with a two-entry out queue.
// Depends on dcsd_pkg.
`timescale 1ns / 1ps
module dcsd_back import dcsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cls_valid,
  output logic        cls_ready,
  input  cls_word_t   cls_data,
  input  logic [31:0] src_len,
  input  logic [31:0] dlt_len,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_CNT  = 3'd3;
  localparam logic [2:0] PH_OFF  = 3'd4;
  localparam logic [2:0] PH_LIT  = 3'd5;

  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] acc_r, acc_nxt, exp_r, exp_nxt, tot_r, tot_nxt;
  logic [31:0] pend_r, pend_nxt, lrem_r, lrem_nxt, used_r, used_nxt;

  out_word_t  q_r [2];
  logic [1:0] qn_r;
  out_word_t  r0, r1;
  logic [1:0] rn;
  logic       take;

  assign cls_ready = (qn_r == 2'd0) || (qn_r == 2'd1 && out_ready);
  assign take = cls_valid && cls_ready;
  assign out_valid = qn_r != 2'd0;
  assign out_data = q_r[0];

  function automatic out_word_t mk(input logic [1:0] k, input logic [7:0] l,
                                   input logic [31:0] o, input logic [31:0] c,
                                   input logic [31:0] t, input logic [31:0] tr,
                                   input logic [3:0] e);
    out_word_t w;
    w.kind = k; w.literal_byte = l; w.copy_offset = o; w.copy_count = c;
    w.output_total = t; w.trailer_value = tr; w.error_code = e; w.last_of_run = 1'b0;
    mk = w;
  endfunction

  always_comb begin
    logic [2:0]  p;
    logic [31:0] acc, ex, tot, pend, lrem, used, sum, shacc;
    logic [7:0]  b;
    logic        eod;
    logic [1:0]  n;
    out_word_t   e0, e1;
    p = ph_r; acc = acc_r; ex = exp_r; tot = tot_r; pend = pend_r;
    lrem = lrem_r; used = used_r;
    b = cls_data.data;
    n = 2'd0; e0 = '0; e1 = '0;
    eod = 1'b0;
    sum = '0;
    if (cls_data.start) begin
      p = PH_HDR; acc = '0; ex = '0; tot = '0; pend = '0; lrem = '0; used = '0;
    end
    shacc = {acc[25:0], 6'd0} + {26'd0, cls_data.digit};
    if (p != PH_IDLE) begin
      if (used == dlt_len) eod = 1'b1;
      else begin
        used = used + 32'd1;
        unique case (p)
          PH_HDR: begin
            if (cls_data.is_digit) acc = shacc;
            else if (b == CH_NL) begin ex = acc; acc = '0; p = PH_CMD; end
            else begin e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_HDR_NL); n = 2'd1; p = PH_IDLE; end
          end
          PH_CMD, PH_CNT, PH_OFF: begin
            if (p == PH_CMD && b == 8'd0) begin
              e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNTERM); n = 2'd1; p = PH_IDLE;
            end else if (cls_data.is_digit) begin
              acc = shacc;
              if (p == PH_CMD) p = PH_CNT;
            end else if (p == PH_OFF) begin
              if (b == CH_COMMA) begin
                tot = tot + pend;
                sum = acc + pend;
                if (tot > ex) begin
                  e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_COPY_SIZE); n = 2'd1; p = PH_IDLE;
                end else if (sum > src_len) begin
                  e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_COPY_SRC); n = 2'd1; p = PH_IDLE;
                end else begin
                  e0 = mk(KIND_COPY, '0, acc, pend, '0, '0, '0); n = 2'd1;
                  acc = '0; p = PH_CMD;
                end
              end else begin
                e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_NO_COMMA); n = 2'd1; p = PH_IDLE;
              end
            end else begin
              if (b == CH_AT) begin pend = acc; acc = '0; p = PH_OFF; end
              else if (b == CH_COLON) begin
                tot = tot + acc;
                if (tot > ex) begin
                  e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_INS_SIZE); n = 2'd1; p = PH_IDLE;
                end else if (acc > dlt_len - used) begin
                  e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_INS_DELTA); n = 2'd1; p = PH_IDLE;
                end else begin
                  lrem = acc; p = (acc != '0) ? PH_LIT : PH_CMD;
                end
                acc = '0;
              end else if (b == CH_SEMI) begin
                if (tot != ex) begin
                  e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_FINAL_SIZE); n = 2'd1;
                end else begin
                  e0 = mk(KIND_DONE, '0, '0, '0, tot, acc, '0); n = 2'd1;
                end
                acc = '0; p = PH_IDLE;
              end else begin
                e0 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNK_OP); n = 2'd1;
                acc = '0; p = PH_IDLE;
              end
            end
          end
          PH_LIT: begin
            e0 = mk(KIND_LIT, b, '0, '0, '0, '0, '0); n = 2'd1;
            lrem = lrem - 32'd1;
            if (lrem == '0) p = PH_CMD;
          end
          default: ;
        endcase
        if (p != PH_IDLE && used == dlt_len) eod = 1'b1;
      end
      if (eod) begin
        case (p)
          PH_HDR: begin e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_HDR_NL); p = PH_IDLE; end
          PH_CNT: begin e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNK_OP); p = PH_IDLE; end
          PH_CMD, PH_LIT: begin
            e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNTERM); p = PH_IDLE;
          end
          PH_OFF: begin
            tot = tot + pend;
            sum = acc + pend;
            if (tot > ex) e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_COPY_SIZE);
            else if (sum > src_len) e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_COPY_SRC);
            else begin
              e1 = mk(KIND_COPY, '0, acc, pend, '0, '0, '0);
              acc = '0;
              if (n == 2'd0) begin e0 = e1; n = 2'd1; end
              else n = 2'd2;
              e1 = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNTERM);
            end
            p = PH_IDLE;
          end
          default: ;
        endcase
        if (p == PH_IDLE && (e1.kind != KIND_LIT || e1.error_code != 4'd0 ||
                             e1 != '0)) begin
          if (n == 2'd0) begin e0 = e1; n = 2'd1; end
          else n = 2'd2;
        end
      end
    end
    if (n == 2'd1) e0.last_of_run = 1'b1;
    if (n == 2'd2) e1.last_of_run = 1'b1;
    r0 = e0; r1 = e1; rn = n;
    ph_nxt = p; acc_nxt = acc; exp_nxt = ex; tot_nxt = tot; pend_nxt = pend;
    lrem_nxt = lrem; used_nxt = used;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; acc_r <= '0; exp_r <= '0; tot_r <= '0;
      pend_r <= '0; lrem_r <= '0; used_r <= '0; qn_r <= 2'd0;
    end else begin
      if (take) begin
        ph_r <= ph_nxt; acc_r <= acc_nxt; exp_r <= exp_nxt; tot_r <= tot_nxt;
        pend_r <= pend_nxt; lrem_r <= lrem_nxt; used_r <= used_nxt;
        qn_r <= rn;
        q_r[0] <= r0;
        q_r[1] <= r1;
      end else if (out_valid && out_ready) begin
        qn_r <= qn_r - 2'd1;
        q_r[0] <= q_r[1];
      end
    end
  end
endmodule

// File: src/delta_command_stream_decoder.sv
// Delta command stream decoder top: config registers, front, queue, back.
// Path: front register, then the queue, then the back end's out queue.
// Throughput: one input word per cycle; out back-pressure or two results stall it.
// Reset: synchronous active-low rst_n clears parse state, queues and registers.
// Depends on dcsd_pkg, dcsd_front, dcsd_fifo, dcsd_back.
`timescale 1ns / 1ps
module delta_command_stream_decoder import dcsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] src_len_r, dlt_len_r;
  logic        f_valid, f_ready, b_valid, b_ready;
  cls_word_t   f_data, b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_len_r <= '0;
      dlt_len_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        CFG_SRC_LEN:   src_len_r <= cfg_data;
        CFG_DELTA_LEN: dlt_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dcsd_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data));
  dcsd_fifo u_fifo (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));
  dcsd_back u_back (.clk, .rst_n, .cls_valid(b_valid), .cls_ready(b_ready), .cls_data(b_data),
    .src_len(src_len_r), .dlt_len(dlt_len_r), .out_valid, .out_ready, .out_data);
endmodule

// File: src/dcsd_checker.sv
// Port checker for the delta command stream decoder, bound to the top level.
// Depends on dcsd_pkg.
`timescale 1ns / 1ps
module dcsd_checker import dcsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERR |-> out_data.error_code <= ERR_UNTERM)
    else $error("error code");
  a_lit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_LIT |-> out_data.copy_offset == '0 &&
    out_data.copy_count == '0) else $error("literal word");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("reset");
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_ready})) else $error("input handshake");
endmodule

bind delta_command_stream_decoder dcsd_checker u_chk (.clk, .rst_n, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_data);
